@@ hdl/primitive_to_triangle_assembler_core_assert.svh @@
// Assertion macros used by the checker of the primitive-to-triangle assembler.
// Every property is sampled on the rising edge of clock and is off while reset is high.
`ifndef PRIMITIVE_TO_TRIANGLE_ASSEMBLER_CORE_ASSERT_SVH
`define PRIMITIVE_TO_TRIANGLE_ASSEMBLER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTA_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pta assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PTA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pta assertion failed");

`endif

@@ hdl/pta_pkg.sv @@
`default_nettype none

package pta_pkg;

   // Width of one vertex index.
   localparam int INDEX_WIDTH = 16;

   // Depth of the result queue; a power of two, at least two.
   localparam int QUEUE_DEPTH = 4;

   // Primitive modes. Codes above MODE_QUAD_STRIP all pass indices through.
   localparam logic [2:0] MODE_TRIANGLES  = 3'd0;
   localparam logic [2:0] MODE_STRIP      = 3'd1;
   localparam logic [2:0] MODE_FAN        = 3'd2;
   localparam logic [2:0] MODE_QUADS      = 3'd3;
   localparam logic [2:0] MODE_QUAD_STRIP = 3'd4;

   // Kinds of result word.
   localparam logic KIND_TRIANGLE = 1'b0;
   localparam logic KIND_PASS     = 1'b1;

   typedef struct packed {
      logic                   out_kind;
      logic [INDEX_WIDTH-1:0] vert_a;
      logic [INDEX_WIDTH-1:0] vert_b;
      logic [INDEX_WIDTH-1:0] vert_c;
      logic                   last_of_run;
   } rsp_word_type;

   // Up to two result words written into the queue in one cycle.
   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type word0;
      rsp_word_type word1;
   } push_type;

endpackage

`default_nettype wire

@@ hdl/pta_rsp_queue.sv @@
`default_nettype none

module pta_rsp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pta_pkg::push_type     push,
   output logic                       room,
   output logic                       pop_valid,
   input  wire logic                  pop_stall,
   output pta_pkg::rsp_word_type      pop_word
);
   import pta_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rsp_word_type     mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   // A push of two words is only offered when two entries are free.
   assign room      = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));
   assign pop_valid = (count_ff != '0);
   assign pop_word  = mem_ff[rd_ptr_ff];
   assign pop       = pop_valid && !pop_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.word0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push.word1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/primitive_to_triangle_assembler_core.sv @@
// Primitive-to-triangle assembler.
// The req channel carries one vertex index per word, tagged with a primitive mode
// (req_func) and a flag that marks the first index of a draw command. The mode is
// latched on that first index and held for the rest of the command. The rsp channel
// carries triangles as index triples, or single indices in pass-through modes; an
// input word yields zero, one or two result words, and the final one carries
// rsp_last_of_run. Both channels move a word on a clock edge where valid is high
// and stall is low.
// An accepted word is held in the input register, assembled from there as it moves
// on, and written into the result queue, which drives rsp.
// Throughput: one input word per cycle in every mode while rsp is not stalled. Quads
// emit two results on every fourth word and quad strips two on every second word;
// a four-entry result queue absorbs each burst and drains one result word per cycle.
// req_stall rises only while the input register holds a word and the queue has
// fewer than two free entries, so a stalled receiver backs the block up and
// nothing is dropped.
// Synchronous reset empties the pipeline and the queue and clears the held mode
// (triangles), the saved indices and the phase counters.
`default_nettype none

module primitive_to_triangle_assembler_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [2:0]                      req_func,
   input  wire logic                            req_first_of_cmd,
   input  wire logic [pta_pkg::INDEX_WIDTH-1:0] req_vertex_index,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_out_kind,
   output logic [pta_pkg::INDEX_WIDTH-1:0]      rsp_vert_a,
   output logic [pta_pkg::INDEX_WIDTH-1:0]      rsp_vert_b,
   output logic [pta_pkg::INDEX_WIDTH-1:0]      rsp_vert_c,
   output logic                                 rsp_last_of_run
);
   import pta_pkg::*;

   // Input register.
   logic                   in_valid_ff, in_valid_in;
   logic [2:0]             in_func_ff;
   logic                   in_first_ff;
   logic [INDEX_WIDTH-1:0] in_vertex_ff;

   // Assembly state.
   logic [2:0]             mode_ff, mode_in;
   logic [INDEX_WIDTH-1:0] anchor_ff, anchor_in;
   logic [INDEX_WIDTH-1:0] prev_one_ff, prev_two_ff;
   logic [1:0]             pos_ff, pos_in;
   logic [1:0]             ph4_ff, ph4_in;
   logic [1:0]             ph3_ff, ph3_in;

   logic                   room;
   logic                   advance;
   logic                   req_accept;
   push_type               push;
   rsp_word_type           pop_word;

   // Effective counters and anchor for the word in the input register.
   logic [1:0]             pos, ph4, ph3;
   logic [INDEX_WIDTH-1:0] v, p1, p2, anchor_cur;

   // The input register moves on whenever the queue can take a two-word burst.
   assign advance    = in_valid_ff && room;
   assign req_stall  = in_valid_ff && !room;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = req_accept || (in_valid_ff && !advance);

      v   = in_vertex_ff;
      p1  = prev_one_ff;
      p2  = prev_two_ff;
      pos = in_first_ff ? 2'd0 : pos_ff;
      ph4 = in_first_ff ? 2'd0 : ph4_ff;
      ph3 = in_first_ff ? 2'd0 : ph3_ff;
      mode_in = in_first_ff ? in_func_ff : mode_ff;

      // The first index of a command always becomes the anchor.
      anchor_cur = (pos == 2'd0) ? v : anchor_ff;
      anchor_in  = anchor_cur;

      push       = '0;

      case (mode_in)
         MODE_TRIANGLES: begin
            if (ph3 == 2'd2) begin
               push.count = 2'd1;
               push.word0 = '{KIND_TRIANGLE, p2, p1, v, 1'b0};
            end
         end
         MODE_STRIP: begin
            // Odd triangles swap their first two vertices to keep the winding.
            if (pos[1]) begin
               push.count = 2'd1;
               if (ph4[0]) begin
                  push.word0 = '{KIND_TRIANGLE, p1, p2, v, 1'b0};
               end else begin
                  push.word0 = '{KIND_TRIANGLE, p2, p1, v, 1'b0};
               end
            end
         end
         MODE_FAN: begin
            if (pos[1]) begin
               push.count = 2'd1;
               push.word0 = '{KIND_TRIANGLE, anchor_cur, p1, v, 1'b0};
            end
         end
         MODE_QUADS: begin
            if (ph4 == 2'd0) begin
               anchor_in = v;
            end
            if (ph4 == 2'd3) begin
               push.count = 2'd2;
               push.word0 = '{KIND_TRIANGLE, anchor_cur, p2, p1, 1'b0};
               push.word1 = '{KIND_TRIANGLE, anchor_cur, p1, v, 1'b0};
            end
         end
         MODE_QUAD_STRIP: begin
            // From the fourth index on, every second index closes a quad against the saved base vertex.
            if (ph4[0]) begin
               if (pos == 2'd3) begin
                  push.count = 2'd2;
                  push.word0 = '{KIND_TRIANGLE, anchor_cur, p2, v, 1'b0};
                  push.word1 = '{KIND_TRIANGLE, anchor_cur, v, p1, 1'b0};
               end
               anchor_in = p1;
            end
         end
         default: begin
            push.count = 2'd1;
            push.word0 = '{KIND_PASS, v, '0, '0, 1'b0};
         end
      endcase

      if (push.count == 2'd1) begin
         push.word0.last_of_run = 1'b1;
      end
      if (push.count == 2'd2) begin
         push.word1.last_of_run = 1'b1;
      end
      if (!advance) begin
         push.count = 2'd0;
      end

      pos_in = (pos == 2'd3) ? 2'd3 : pos + 2'd1;
      ph4_in = ph4 + 2'd1;
      ph3_in = (ph3 >= 2'd2) ? 2'd0 : ph3 + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_func_ff   <= req_func;
         in_first_ff  <= req_first_of_cmd;
         in_vertex_ff <= req_vertex_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_TRIANGLES;
         anchor_ff   <= '0;
         prev_one_ff <= '0;
         prev_two_ff <= '0;
         pos_ff      <= '0;
         ph4_ff      <= '0;
         ph3_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            mode_ff     <= mode_in;
            anchor_ff   <= anchor_in;
            prev_one_ff <= v;
            prev_two_ff <= p1;
            pos_ff      <= pos_in;
            ph4_ff      <= ph4_in;
            ph3_ff      <= ph3_in;
         end
      end
   end

   pta_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .pop_valid (rsp_valid),
      .pop_stall (rsp_stall),
      .pop_word  (pop_word)
   );

   assign rsp_out_kind    = pop_word.out_kind;
   assign rsp_vert_a      = pop_word.vert_a;
   assign rsp_vert_b      = pop_word.vert_b;
   assign rsp_vert_c      = pop_word.vert_c;
   assign rsp_last_of_run = pop_word.last_of_run;

endmodule

`default_nettype wire

@@ hdl/pta_checker.sv @@
`default_nettype none

`include "primitive_to_triangle_assembler_core_assert.svh"

module pta_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_stall,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic                            rsp_out_kind,
   input wire logic [pta_pkg::INDEX_WIDTH-1:0] rsp_vert_a,
   input wire logic [pta_pkg::INDEX_WIDTH-1:0] rsp_vert_b,
   input wire logic [pta_pkg::INDEX_WIDTH-1:0] rsp_vert_c,
   input wire logic                            rsp_last_of_run
);
   import pta_pkg::*;

   // A stalled result word stays offered.
   `PTA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

   // A stalled result word does not change.
   `PTA_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_vert_a) && $stable(rsp_vert_b) && $stable(rsp_vert_c) && $stable(rsp_out_kind) && $stable(rsp_last_of_run))

   // A pass-through word carries one index and always closes its run.
   `PTA_ASSERT_SAME(a_pass_word, rsp_valid && (rsp_out_kind == KIND_PASS), (rsp_vert_b == '0) && (rsp_vert_c == '0) && rsp_last_of_run)

   // With the result queue empty there is always room, so the input never stalls.
   `PTA_ASSERT_SAME(a_no_stall_when_empty, !rsp_valid, !req_stall)

endmodule

bind primitive_to_triangle_assembler_core pta_checker u_pta_checker (.*);

`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none

// Self-checking bench for the primitive-to-triangle assembler.
//
// A queue of index words is filled up front by the stimulus block: a short
// directed run through every primitive mode, then random draw commands of
// random length and mode with random index values. The driver pops the queue
// onto the req channel. When a word is accepted, the driver runs it through
// a local model of the assembler, which appends the triangles or pass-through
// indices it owes to a queue of awaited primitives. The monitor pops that
// queue on every accepted rsp word and compares the fields.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pta_pkg::*;

   // Mode codes past the quad strip. The block passes indices through for all of them.
   localparam logic [2:0] MODE_PASS      = 3'd5;
   localparam logic [2:0] MODE_PASS_ALT1 = 3'd6;
   localparam logic [2:0] MODE_PASS_ALT2 = 3'd7;

   // Idling on both channels stops once this few index words remain to be sent.
   localparam int TAIL_WORDS = 150;

   typedef struct {
      logic [2:0]             func;
      logic                   first;
      logic [INDEX_WIDTH-1:0] vidx;
      bit                     drain_first;   // hold this word back until rsp is empty
   } index_word_type;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic [2:0]             req_func         = '0;
   logic                   req_first_of_cmd = 1'b0;
   logic [INDEX_WIDTH-1:0] req_vertex_index = '0;
   logic                   rsp_stall        = 1'b0;
   logic                   req_stall;
   logic                   rsp_valid;
   logic                   rsp_out_kind;
   logic [INDEX_WIDTH-1:0] rsp_vert_a;
   logic [INDEX_WIDTH-1:0] rsp_vert_b;
   logic [INDEX_WIDTH-1:0] rsp_vert_c;
   logic                   rsp_last_of_run;

   index_word_type index_stream[$];
   rsp_word_type   awaited_prims[$];
   index_word_type bus_word;
   int             mismatches = 0;

   // State of the local assembler model. It mirrors the block's state after reset.
   logic [2:0]             held_mode  = MODE_TRIANGLES;
   logic [INDEX_WIDTH-1:0] anchor_v   = '0;
   logic [INDEX_WIDTH-1:0] last_v     = '0;
   logic [INDEX_WIDTH-1:0] older_v    = '0;
   logic [1:0]             pos_seen   = '0;
   logic [1:0]             phase4     = '0;
   logic [1:0]             phase3     = '0;

   primitive_to_triangle_assembler_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_first_of_cmd (req_first_of_cmd),
      .req_vertex_index (req_vertex_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_kind     (rsp_out_kind),
      .rsp_vert_a       (rsp_vert_a),
      .rsp_vert_b       (rsp_vert_b),
      .rsp_vert_c       (rsp_vert_c),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic rsp_word_type make_prim(input logic kind,
                                              input logic [INDEX_WIDTH-1:0] a,
                                              input logic [INDEX_WIDTH-1:0] b,
                                              input logic [INDEX_WIDTH-1:0] c);
      rsp_word_type w;
      w.out_kind    = kind;
      w.vert_a      = a;
      w.vert_b      = b;
      w.vert_c      = c;
      w.last_of_run = 1'b0;
      return w;
   endfunction

   // Assemble one accepted index word and queue the primitives it completes.
   task automatic assemble_index(input index_word_type w);
      rsp_word_type           made[2];
      int                     n;
      int                     i;
      logic [1:0]             pos;
      logic [1:0]             ph4;
      logic [1:0]             ph3;
      logic [INDEX_WIDTH-1:0] v;
      logic [INDEX_WIDTH-1:0] p1;
      logic [INDEX_WIDTH-1:0] p2;
      n = 0;
      v = w.vidx;
      // The start flag latches the mode and restarts every position counter.
      // Without it the func field is ignored.
      if (w.first) begin
         held_mode = w.func;
         pos = 2'd0;
         ph4 = 2'd0;
         ph3 = 2'd0;
      end else begin
         pos = pos_seen;
         ph4 = phase4;
         ph3 = phase3;
      end
      p1 = last_v;
      p2 = older_v;
      if (pos == 2'd0) anchor_v = v;

      case (held_mode)
         MODE_TRIANGLES: begin
            if (ph3 == 2'd2) begin
               made[n] = make_prim(KIND_TRIANGLE, p2, p1, v);
               n++;
            end
         end
         MODE_STRIP: begin
            // Odd triangles of a strip swap their first two vertices to keep the winding.
            if (pos >= 2'd2) begin
               if (ph4[0]) made[n] = make_prim(KIND_TRIANGLE, p1, p2, v);
               else        made[n] = make_prim(KIND_TRIANGLE, p2, p1, v);
               n++;
            end
         end
         MODE_FAN: begin
            if (pos >= 2'd2) begin
               made[n] = make_prim(KIND_TRIANGLE, anchor_v, p1, v);
               n++;
            end
         end
         MODE_QUADS: begin
            if (ph4 == 2'd0) anchor_v = v;
            if (ph4 == 2'd3) begin
               made[n] = make_prim(KIND_TRIANGLE, anchor_v, p2, p1);
               n++;
               made[n] = make_prim(KIND_TRIANGLE, anchor_v, p1, v);
               n++;
            end
         end
         MODE_QUAD_STRIP: begin
            // From the fourth index on, every second index closes a quad against the previous pair, then the
            // index just before it becomes the base of the next quad.
            if (ph4[0]) begin
               if (pos >= 2'd3) begin
                  made[n] = make_prim(KIND_TRIANGLE, anchor_v, p2, v);
                  n++;
                  made[n] = make_prim(KIND_TRIANGLE, anchor_v, v, p1);
                  n++;
               end
               anchor_v = p1;
            end
         end
         default: begin
            made[n] = make_prim(KIND_PASS, v, '0, '0);
            n++;
         end
      endcase

      for (i = 0; i < n; i++) begin
         if (i == n - 1) made[i].last_of_run = 1'b1;
         awaited_prims = {awaited_prims, made[i]};
      end

      older_v  = p1;
      last_v   = v;
      pos_seen = (pos == 2'd3) ? 2'd3 : pos + 2'd1;
      phase4   = ph4 + 2'd1;
      phase3   = (ph3 >= 2'd2) ? 2'd0 : ph3 + 2'd1;
   endtask

   task automatic add_word(input logic [2:0] func, input logic first,
                           input logic [INDEX_WIDTH-1:0] vidx, input bit drain_first);
      index_word_type w;
      w.func        = func;
      w.first       = first;
      w.vidx        = vidx;
      w.drain_first = drain_first;
      index_stream = {index_stream, w};
   endtask

   // Driver. A new word goes on the bus only when the previous one has been taken
   // or the bus is empty, so a stalled word stays put. Gaps come in random bursts,
   // except during quiet stretches and near the end of the run.
   int gap_left     = 0;
   int drv_calm     = 0;

   always @(posedge clock) begin : driver
      bit show;
      show = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) assemble_index(bus_word);
         if (drv_calm > 0) drv_calm--;
         else if ($urandom_range(0, 39) == 0) drv_calm = $urandom_range(20, 120);

         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (index_stream.size() != 0) begin
               if (index_stream[0].drain_first && awaited_prims.size() != 0) begin
                  // Hold off until the block has handed back everything it owes.
               end else if (index_stream.size() > TAIL_WORDS && drv_calm == 0 &&
                            $urandom_range(0, 5) == 0) begin
                  gap_left = $urandom_range(1, 11) - 1;
               end else begin
                  show = 1'b1;
               end
            end
            if (show) begin
               bus_word = index_stream.pop_front();
               req_func         <= bus_word.func;
               req_first_of_cmd <= bus_word.first;
               req_vertex_index <= bus_word.vidx;
            end
            req_valid <= show;
         end
      end
   end

   // Monitor. Every accepted rsp word must match the oldest awaited primitive.
   // The stall is raised in random bursts the same way the driver idles.
   int stall_left = 0;
   int mon_calm   = 0;

   always @(posedge clock) begin : monitor
      rsp_word_type want;
      bit           bad;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_prims.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected rsp word kind=%0d a=%h b=%h c=%h last=%0d",
                        $realtime, rsp_out_kind, rsp_vert_a, rsp_vert_b, rsp_vert_c,
                        rsp_last_of_run);
         end else begin
            want = awaited_prims.pop_front();
            bad  = (rsp_out_kind    !== want.out_kind) ||
                   (rsp_vert_a      !== want.vert_a)   ||
                   (rsp_vert_b      !== want.vert_b)   ||
                   (rsp_vert_c      !== want.vert_c)   ||
                   (rsp_last_of_run !== want.last_of_run);
            if (bad) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: rsp mismatch, expected kind=%0d a=%h b=%h c=%h last=%0d",
                           $realtime, want.out_kind, want.vert_a, want.vert_b,
                           want.vert_c, want.last_of_run);
                  $display("   got kind=%0d a=%h b=%h c=%h last=%0d",
                           rsp_out_kind, rsp_vert_a, rsp_vert_b, rsp_vert_c,
                           rsp_last_of_run);
               end
            end
         end
      end

      if (mon_calm > 0) mon_calm--;
      else if ($urandom_range(0, 39) == 0) mon_calm = $urandom_range(20, 120);

      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (index_stream.size() > TAIL_WORDS && mon_calm == 0 &&
                   $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 11) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Stimulus and end of run.
   initial begin : stimulus
      int                     guard;
      int                     len;
      int                     cmds;
      int                     i;
      logic [2:0]             mode;
      logic [INDEX_WIDTH-1:0] v;

      // Indices ahead of any command start run in the reset mode, triangles.
      add_word(MODE_QUADS, 1'b0, 16'h0000, 1'b0);
      add_word(MODE_STRIP, 1'b0, 16'hFFFF, 1'b0);
      add_word(MODE_PASS,  1'b0, 16'h1234, 1'b0);
      // Triangle list; the func field on words without the start flag is ignored.
      add_word(MODE_TRIANGLES, 1'b1, 16'hFFFF, 1'b0);
      add_word(MODE_PASS_ALT2, 1'b0, 16'h0000, 1'b0);
      add_word(MODE_FAN,       1'b0, 16'h8001, 1'b0);
      // Strip: the second triangle has its winding swapped.
      add_word(MODE_STRIP, 1'b1, 16'h0001, 1'b0);
      add_word(MODE_STRIP, 1'b0, 16'h0002, 1'b0);
      add_word(MODE_STRIP, 1'b0, 16'h0003, 1'b0);
      add_word(MODE_STRIP, 1'b0, 16'h0004, 1'b0);
      // Fan keeps its first index as the shared corner.
      add_word(MODE_FAN, 1'b1, 16'hAAAA, 1'b0);
      add_word(MODE_FAN, 1'b0, 16'h5555, 1'b0);
      add_word(MODE_FAN, 1'b0, 16'hFFFF, 1'b0);
      add_word(MODE_FAN, 1'b0, 16'h0000, 1'b0);
      // One quad, two triangles at its last corner.
      add_word(MODE_QUADS, 1'b1, 16'h0010, 1'b0);
      add_word(MODE_QUADS, 1'b0, 16'h0020, 1'b0);
      add_word(MODE_QUADS, 1'b0, 16'h0030, 1'b0);
      add_word(MODE_QUADS, 1'b0, 16'h0040, 1'b0);
      // Quad strip: the first pair opens it, the second closes one quad.
      add_word(MODE_QUAD_STRIP, 1'b1, 16'h0000, 1'b0);
      add_word(MODE_QUAD_STRIP, 1'b0, 16'hFFFF, 1'b0);
      add_word(MODE_QUAD_STRIP, 1'b0, 16'h7FFF, 1'b0);
      add_word(MODE_QUAD_STRIP, 1'b0, 16'h8000, 1'b0);
      // Pass-through, including the two codes above it and a word without the flag.
      add_word(MODE_PASS,      1'b1, 16'hFFFF, 1'b0);
      add_word(MODE_PASS_ALT1, 1'b1, 16'h0000, 1'b0);
      add_word(MODE_PASS_ALT2, 1'b1, 16'hC3C3, 1'b0);
      add_word(MODE_TRIANGLES, 1'b0, 16'h3C3C, 1'b0);

      // Random draw commands. Most are polygon modes, now and then a longer one,
      // and every so often the sender waits for the block to drain first.
      cmds = 0;
      while (index_stream.size() < 1775) begin
         if ($urandom_range(0, 9) < 8) mode = 3'($urandom_range(MODE_TRIANGLES, MODE_QUAD_STRIP));
         else                          mode = 3'($urandom_range(MODE_PASS, MODE_PASS_ALT2));
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else                            v = 16'($urandom);
            add_word((i == 0) ? mode : 3'($urandom), i == 0, v,
                     i == 0 && cmds % 60 == 0);
         end
         cmds++;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (index_stream.size() != 0 || req_valid) @(posedge clock);
      guard = 0;
      while (awaited_prims.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      // Anything still awaited never came back.
      mismatches += awaited_prims.size();
      repeat (10) @(posedge clock);

      if (mismatches == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #5ms;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
